[rtl/c2a_pkg.sv]
`timescale 1ns / 1ps
package c2a_pkg;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int PIX_W = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_RED = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_GREEN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_BLUE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_ALPHA = 3'd3;

   localparam int ALPHA_STEPS = 4;
   localparam int ADJ_STEPS = 2;
   localparam int ADJ_Q_W = 10;
   localparam int NUM_CHAN = 3;

   typedef logic [PIX_W-1:0] pix_type;
   localparam pix_type PIX_MAX = 8'hFF;

   function automatic int alpha_stages(input int frac);
      return (frac + 2 + ALPHA_STEPS - 1) / ALPHA_STEPS;
   endfunction

   function automatic int adj_stages();
      return (ADJ_Q_W + ADJ_STEPS - 1) / ADJ_STEPS;
   endfunction
endpackage

[rtl/c2a_div.sv]
`timescale 1ns / 1ps
module c2a_div #(
   parameter int N = 16,
   parameter int M = 8,
   parameter int Q = 8,
   parameter int LANES = 1,
   parameter int SIDE_W = 1,
   parameter int STEPS = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [LANES-1:0][N-1:0]   in_dividend,
   input  logic [LANES-1:0][M-1:0]   in_divisor,
   input  logic [SIDE_W-1:0]         in_side,
   output logic                      out_valid,
   output logic [LANES-1:0][Q-1:0]   out_quotient,
   output logic [SIDE_W-1:0]         out_side
);
   localparam int NST = (Q + STEPS - 1) / STEPS;

   logic [NST:0]                valid_ff;
   logic [NST:0]                valid_in;
   logic [LANES-1:0][M-1:0]     rem_ff  [NST+1];
   logic [LANES-1:0][M-1:0]     rem_in  [NST+1];
   logic [LANES-1:0][Q-1:0]     quo_ff  [NST+1];
   logic [LANES-1:0][Q-1:0]     quo_in  [NST+1];
   logic [LANES-1:0][M-1:0]     dvs_ff  [NST+1];
   logic [LANES-1:0][M-1:0]     dvs_in  [NST+1];
   logic [SIDE_W-1:0]           side_ff [NST+1];
   logic [SIDE_W-1:0]           side_in [NST+1];

   // restoring division, remainder on top of the shifting quotient
   always_comb begin
      logic [M:0]   t;
      logic [M-1:0] r;
      logic [Q-1:0] x;
      valid_in[0] = in_valid;
      dvs_in[0] = in_divisor;
      side_in[0] = in_side;
      for (int l = 0; l < LANES; l++) begin
         rem_in[0][l] = M'(in_dividend[l][N-1:Q]);
         quo_in[0][l] = in_dividend[l][Q-1:0];
      end
      for (int s = 0; s < NST; s++) begin
         valid_in[s+1] = valid_ff[s];
         dvs_in[s+1] = dvs_ff[s];
         side_in[s+1] = side_ff[s];
         for (int l = 0; l < LANES; l++) begin
            r = rem_ff[s][l];
            x = quo_ff[s][l];
            for (int j = 0; j < STEPS; j++) begin
               if (s * STEPS + j < Q) begin
                  t = {r, x[Q-1]};
                  if (t >= {1'b0, dvs_ff[s][l]}) begin
                     t = t - {1'b0, dvs_ff[s][l]};
                     x = {x[Q-2:0], 1'b1};
                  end else begin
                     x = {x[Q-2:0], 1'b0};
                  end
                  r = t[M-1:0];
               end
            end
            rem_in[s+1][l] = r;
            quo_in[s+1][l] = x;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      side_ff <= side_in;
   end

   assign out_valid = valid_ff[NST];
   assign out_quotient = quo_ff[NST];
   assign out_side = side_ff[NST];
endmodule

[rtl/color_to_alpha_pixel_top.sv]
// Registers in order: input, alpha divider, max, product, color divider, output.
// Throughput: one item per cycle; busy is high only while reset is high.
// Depth is set by two pipelined restoring dividers: the channel alpha divider
// (4 quotient bits per stage) and the color divider (2 quotient bits per stage).
// Reset is synchronous: clears all valid bits and restores the key registers.
`timescale 1ns / 1ps
module color_to_alpha_pixel_top #(
   parameter int FRACTION_BITS = c2a_pkg::FRACTION_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  c2a_pkg::pix_type                       req_in_red,
   input  c2a_pkg::pix_type                       req_in_green,
   input  c2a_pkg::pix_type                       req_in_blue,
   input  c2a_pkg::pix_type                       req_in_alpha,
   output logic                                   rsp_valid,
   output c2a_pkg::pix_type                       rsp_out_red,
   output c2a_pkg::pix_type                       rsp_out_green,
   output c2a_pkg::pix_type                       rsp_out_blue,
   output c2a_pkg::pix_type                       rsp_out_alpha,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [c2a_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [c2a_pkg::CSR_DATA_W-1:0]         csr_data
);
   import c2a_pkg::*;

   localparam int F = FRACTION_BITS;
   localparam int A_W = F + 1;
   localparam int AQ_W = F + 2;
   localparam int AN_W = PIX_W + F + 1;
   localparam int BN_W = F + 10;
   localparam int BM_W = F + 2;
   localparam int P_W = F + 10;
   localparam int SP_W = F + 9;
   localparam int V_W = F + 11;
   localparam int SIDE_A_W = 4 * PIX_W;
   localparam int SIDE_B_W = 3 * PIX_W + 1 + NUM_CHAN + PIX_W;
   localparam int LATENCY = alpha_stages(F) + adj_stages() + 6;

   pix_type                key_ff [NUM_CHAN];
   logic                   has_alpha_ff;

   logic                   valid0_ff;
   pix_type                pix0_ff [NUM_CHAN];
   pix_type                sa0_ff;

   logic [NUM_CHAN-1:0][AN_W-1:0]  diva_num;
   logic [NUM_CHAN-1:0][PIX_W-1:0] diva_den;
   logic                           diva_valid;
   logic [NUM_CHAN-1:0][AQ_W-1:0]  diva_q;
   logic [SIDE_A_W-1:0]            diva_side;

   logic [A_W-1:0]         a1_in;
   logic                   valid1_ff;
   logic [A_W-1:0]         a1_ff;
   logic [SIDE_A_W-1:0]    side1_ff;

   logic                   valid2_ff;
   logic [A_W-1:0]         a2_ff;
   pix_type                pix2_ff [NUM_CHAN];
   logic [P_W-1:0]         prod2_ff [NUM_CHAN];
   logic [SP_W-1:0]        aprod2_ff;

   logic [NUM_CHAN-1:0][BN_W-1:0]  divb_num;
   logic [NUM_CHAN-1:0][BM_W-1:0]  divb_den;
   logic [NUM_CHAN-1:0]            neg2;
   pix_type                        oa2;
   logic                           divb_valid;
   logic [NUM_CHAN-1:0][ADJ_Q_W-1:0] divb_q;
   logic [SIDE_B_W-1:0]            divb_side;

   logic                   rsp_valid_ff;
   pix_type                rsp_ff [NUM_CHAN+1];
   pix_type                rsp_in [NUM_CHAN+1];

   assign busy = reset;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff[0] <= PIX_MAX;
         key_ff[1] <= PIX_MAX;
         key_ff[2] <= PIX_MAX;
         has_alpha_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_KEY_RED:   key_ff[0] <= csr_data[PIX_W-1:0];
            CSR_KEY_GREEN: key_ff[1] <= csr_data[PIX_W-1:0];
            CSR_KEY_BLUE:  key_ff[2] <= csr_data[PIX_W-1:0];
            CSR_SRC_ALPHA: has_alpha_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else begin
         valid0_ff <= start && !busy;
      end
      pix0_ff[0] <= req_in_red;
      pix0_ff[1] <= req_in_green;
      pix0_ff[2] <= req_in_blue;
      sa0_ff <= has_alpha_ff ? req_in_alpha : PIX_MAX;
   end

   // channel alpha numerator and denominator
   always_comb begin
      pix_type num;
      pix_type den;
      for (int c = 0; c < NUM_CHAN; c++) begin
         if (key_ff[c] == '0) begin
            num = pix0_ff[c];
            den = PIX_MAX;
         end else if (pix0_ff[c] > key_ff[c]) begin
            num = pix0_ff[c] - key_ff[c];
            den = PIX_MAX - key_ff[c];
         end else begin
            num = key_ff[c] - pix0_ff[c];
            den = key_ff[c];
         end
         diva_num[c] = {num, {(F+1){1'b0}}};
         diva_den[c] = den;
      end
   end

   c2a_div #(
      .N(AN_W), .M(PIX_W), .Q(AQ_W), .LANES(NUM_CHAN),
      .SIDE_W(SIDE_A_W), .STEPS(ALPHA_STEPS)
   ) u_div_alpha (
      .clock(clock),
      .reset(reset),
      .in_valid(valid0_ff),
      .in_dividend(diva_num),
      .in_divisor(diva_den),
      .in_side({pix0_ff[0], pix0_ff[1], pix0_ff[2], sa0_ff}),
      .out_valid(diva_valid),
      .out_quotient(diva_q),
      .out_side(diva_side)
   );

   // round to nearest, then largest of the three
   always_comb begin
      logic [AQ_W-1:0] inc;
      a1_in = '0;
      for (int c = 0; c < NUM_CHAN; c++) begin
         inc = diva_q[c] + AQ_W'(1);
         if (inc[AQ_W-1:1] > a1_in) begin
            a1_in = inc[AQ_W-1:1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= diva_valid;
         valid2_ff <= valid1_ff;
      end
      a1_ff <= a1_in;
      side1_ff <= diva_side;
      a2_ff <= a1_ff;
      for (int c = 0; c < NUM_CHAN; c++) begin
         pix2_ff[c] <= side1_ff[SIDE_A_W-1-c*PIX_W -: PIX_W];
         prod2_ff[c] <= P_W'(a1_ff) * P_W'({key_ff[c], 1'b1});
      end
      aprod2_ff <= SP_W'(a1_ff) * SP_W'(side1_ff[PIX_W-1:0]);
   end

   // (s-k)*2^(F+1) + a*(2k+1), divided by 2a
   always_comb begin
      logic [PIX_W:0]   diff;
      logic [V_W-1:0]   v;
      logic [SP_W-1:0]  oa_sum;
      for (int c = 0; c < NUM_CHAN; c++) begin
         diff = {1'b0, pix2_ff[c]} - {1'b0, key_ff[c]};
         v = {diff[PIX_W], diff, {(F+1){1'b0}}} + {1'b0, prod2_ff[c]};
         neg2[c] = v[V_W-1];
         divb_num[c] = neg2[c] ? '0 : v[BN_W-1:0];
         divb_den[c] = {a2_ff, 1'b0};
      end
      oa_sum = aprod2_ff + (SP_W'(1) << (F - 1));
      oa2 = oa_sum[F+PIX_W-1:F];
   end

   c2a_div #(
      .N(BN_W), .M(BM_W), .Q(ADJ_Q_W), .LANES(NUM_CHAN),
      .SIDE_W(SIDE_B_W), .STEPS(ADJ_STEPS)
   ) u_div_color (
      .clock(clock),
      .reset(reset),
      .in_valid(valid2_ff),
      .in_dividend(divb_num),
      .in_divisor(divb_den),
      .in_side({pix2_ff[0], pix2_ff[1], pix2_ff[2], a2_ff == '0, neg2, oa2}),
      .out_valid(divb_valid),
      .out_quotient(divb_q),
      .out_side(divb_side)
   );

   always_comb begin
      logic    zero;
      pix_type src;
      zero = divb_side[PIX_W+NUM_CHAN];
      for (int c = 0; c < NUM_CHAN; c++) begin
         src = divb_side[SIDE_B_W-1-c*PIX_W -: PIX_W];
         if (zero) begin
            rsp_in[c] = src;
         end else if (divb_side[PIX_W+c]) begin
            rsp_in[c] = '0;
         end else if (divb_q[c][ADJ_Q_W-1:PIX_W] != '0) begin
            rsp_in[c] = PIX_MAX;
         end else begin
            rsp_in[c] = divb_q[c][PIX_W-1:0];
         end
      end
      rsp_in[NUM_CHAN] = zero ? '0 : divb_side[PIX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= divb_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_red = rsp_ff[0];
   assign rsp_out_green = rsp_ff[1];
   assign rsp_out_blue = rsp_ff[2];
   assign rsp_out_alpha = rsp_ff[NUM_CHAN];
endmodule

[rtl/c2a_checker.sv]
`timescale 1ns / 1ps
module c2a_checker #(
   parameter int LATENCY = 16
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);
   import c2a_pkg::*;

   a_item_returns: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_valid)
      else $error("accepted item did not return");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without accepted item");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe after reset");
endmodule

bind color_to_alpha_pixel_top c2a_checker #(.LATENCY(LATENCY)) u_c2a_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
   import c2a_pkg::*;

   localparam int FB = 16;
   localparam int LATENCY = (FB + 2 + 3) / 4 + 11;
   localparam longint CYCLE_LIMIT = 200000;

   typedef struct packed {
      pix_type r;
      pix_type g;
      pix_type b;
      pix_type a;
   } rgba_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   pix_type req_in_red = 0, req_in_green = 0, req_in_blue = 0, req_in_alpha = 0;
   logic rsp_valid;
   pix_type rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = 0;
   logic [CSR_DATA_W-1:0] csr_data = 0;

   color_to_alpha_pixel_top #(.FRACTION_BITS(FB)) uut (.*);

   pix_type key_r, key_g, key_b;
   logic use_src_alpha;
   rgba_type pending_pixels[$];
   int errors = 0;
   int pixels_sent = 0;
   int pixels_checked = 0;
   longint cycles = 0;

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL color_to_alpha_pixel_top");
         $finish;
      end
   end

   function automatic longint unsigned chan_alpha(input int s, input int k);
      longint unsigned num, den;
      if (k == 0) begin
         num = s;
         den = 255;
      end else if (s > k) begin
         num = s - k;
         den = 255 - k;
      end else if (s < k) begin
         num = k - s;
         den = k;
      end else begin
         return 0;
      end
      return ((num << (FB + 1)) + den) / (2 * den);
   endfunction

   function automatic pix_type adjust_chan(input int s, input int k, input longint a);
      longint v, q;
      v = longint'(s - k) * (longint'(1) << (FB + 1)) + a + 2 * longint'(k) * a;
      if (v < 0) return 0;
      q = v / (2 * a);
      if (q > 255) return 8'hFF;
      return q[7:0];
   endfunction

   function automatic rgba_type unkey_pixel(input rgba_type p);
      longint unsigned a, t, oa;
      int sa;
      rgba_type o;
      sa = use_src_alpha ? int'(p.a) : 255;
      a = chan_alpha(p.r, key_r);
      t = chan_alpha(p.g, key_g);
      if (t > a) a = t;
      t = chan_alpha(p.b, key_b);
      if (t > a) a = t;
      if (a == 0) begin
         o = p;
         o.a = 0;
         return o;
      end
      o.r = adjust_chan(p.r, key_r, a);
      o.g = adjust_chan(p.g, key_g, a);
      o.b = adjust_chan(p.b, key_b, a);
      oa = (a * sa + (longint'(1) << (FB - 1))) >> FB;
      o.a = (oa > 255) ? 8'hFF : oa[7:0];
      return o;
   endfunction

   always @(posedge clock) begin
      rgba_type exp_px;
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t unexpected result %h %h %h %h", $time, rsp_out_red,
                     rsp_out_green, rsp_out_blue, rsp_out_alpha);
            errors++;
         end else begin
            exp_px = pending_pixels.pop_front();
            pixels_checked++;
            if (exp_px != {rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha}) begin
               $display("%0t mismatch exp r%h g%h b%h a%h got r%h g%h b%h a%h", $time,
                        exp_px.r, exp_px.g, exp_px.b, exp_px.a, rsp_out_red,
                        rsp_out_green, rsp_out_blue, rsp_out_alpha);
               errors++;
            end
         end
      end
   end

   int burst_left = 0;

   task automatic send_pixel(input rgba_type p);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 2) != 0) begin
            start <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1;
      req_in_red <= p.r;
      req_in_green <= p.g;
      req_in_blue <= p.b;
      req_in_alpha <= p.a;
      do @(posedge clock); while (busy);
      pending_pixels.push_back(unkey_pixel(p));
      pixels_sent++;
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_KEY_RED: key_r = val[7:0];
         CSR_KEY_GREEN: key_g = val[7:0];
         CSR_KEY_BLUE: key_b = val[7:0];
         CSR_SRC_ALPHA: use_src_alpha = val[0];
         default: ;
      endcase
   endtask

   task automatic set_key(input int r, input int g, input int b, input int sa);
      write_csr(CSR_KEY_RED, r);
      write_csr(CSR_KEY_GREEN, g);
      write_csr(CSR_KEY_BLUE, b);
      write_csr(CSR_SRC_ALPHA, sa);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   function automatic rgba_type rand_pixel();
      rgba_type p;
      p = $urandom;
      return p;
   endfunction

   task automatic test_reset_key();
      send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
      send_pixel('{8'h00, 8'h00, 8'h00, 8'hFF});
      send_pixel('{8'h80, 8'h40, 8'hC0, 8'h7F});
      drain();
   endtask

   task automatic test_directed();
      set_key(0, 128, 255, 1);
      send_pixel('{8'h00, 8'h80, 8'hFF, 8'hFF});
      send_pixel('{8'hFF, 8'h00, 8'h00, 8'h00});
      send_pixel('{8'h01, 8'h81, 8'hFE, 8'h80});
      send_pixel('{8'h10, 8'h7F, 8'h00, 8'hFF});
      send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'h01});
      drain();
      set_key(37, 200, 1, 0);
      send_pixel('{8'd37, 8'd200, 8'd1, 8'h00});
      send_pixel('{8'd38, 8'd199, 8'd0, 8'h55});
      send_pixel('{8'h00, 8'hFF, 8'hFF, 8'hAA});
      send_pixel('{8'hFF, 8'h00, 8'h02, 8'h00});
      drain();
      set_key(254, 1, 0, 1);
      send_pixel('{8'hFF, 8'h00, 8'h00, 8'hFF});
      send_pixel('{8'hFE, 8'h01, 8'h00, 8'hFF});
      send_pixel('{8'h00, 8'hFF, 8'h80, 8'h3C});
      drain();
   endtask

   task automatic test_random();
      int k;
      for (int phase = 0; phase < 8; phase++) begin
         k = $urandom_range(0, 3);
         if (k == 0)
            set_key(0, 0, 0, $urandom_range(0, 1));
         else if (k == 1)
            set_key(255, 255, 255, $urandom_range(0, 1));
         else
            set_key($urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 1));
         for (int i = 0; i < 50; i++) begin
            rgba_type p;
            p = rand_pixel();
            if ($urandom_range(0, 5) == 0) begin
               p.r = key_r;
               p.g = key_g;
               p.b = key_b;
            end
            send_pixel(p);
         end
         drain();
      end
   endtask

   initial begin
      key_r = 8'hFF;
      key_g = 8'hFF;
      key_b = 8'hFF;
      use_src_alpha = 1;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_reset_key();
      test_directed();
      test_random();
      $display("Sent %0d pixels, checked %0d, over many key colors and alpha modes.",
               pixels_sent, pixels_checked);
      if (errors == 0 && pending_pixels.size() == 0) begin
         $display("PASS color_to_alpha_pixel_top");
      end else begin
         $display("FAIL color_to_alpha_pixel_top");
      end
      $finish;
   end
endmodule

[files.f]
rtl/c2a_pkg.sv
rtl/c2a_div.sv
rtl/color_to_alpha_pixel_top.sv
rtl/c2a_checker.sv
tb/tb_top.sv
